// File: rtl/core/fibmod_pkg.sv
// ============================================================================
// fibmod_pkg
// Shared types, constants and the step table of the Fibonacci mod-m engine.
// ============================================================================
package fibmod_pkg;

    // Field and datapath widths
    localparam int EXP_W  = 31;   // exponent field
    localparam int MOD_W  = 16;   // modulus register, matrix elements, result
    localparam int MEFF_W = 17;   // effective modulus (zero means 65536)
    localparam int MU_W   = 32;   // Barrett reciprocal
    localparam int PROD_W = 64;   // shared multiplier product
    localparam int RED_W  = 18;   // partial remainder, below 3*m
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [MOD_W-1:0] MOD_RESET = 16'd10000;
    localparam logic [MU_W-1:0]  MU_RESET  = MU_W'(64'hFFFF_FFFF / 64'(MOD_RESET));

    // Register index (paddr[ADDR_W-1:2])
    localparam logic [ADDR_W-3:0] REG_MODULUS = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        MM_IDLE,
        MM_EST,
        MM_BACK,
        MM_SUB,
        MM_FIX
    } mm_state_t;

    typedef enum logic {
        OP_MUL,
        OP_ADD
    } op_t;

    // Operand / destination registers of the sequencer
    typedef enum logic [2:0] {
        SEL_AP,   // accumulator F(k-1)
        SEL_AQ,   // accumulator F(k)
        SEL_BP,   // base F(j-1)
        SEL_BQ,   // base F(j)
        SEL_BR,   // base F(j+1)
        SEL_T0,
        SEL_T1,
        SEL_T2
    } sel_t;

    typedef logic [3:0] pc_t;

    localparam pc_t PC_BR      = 4'd0;
    localparam pc_t PC_ACC     = 4'd1;
    localparam pc_t PC_ACC_END = 4'd6;
    localparam pc_t PC_SQR     = 4'd7;
    localparam pc_t PC_SQR_END = 4'd11;

    typedef struct packed {
        op_t  op;
        sel_t a;
        sel_t b;
        sel_t dst;
    } uop_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } mm_req_t;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] r;
    } mm_stat_t;

    // Step table for one exponent bit. Matrices are kept as (p, q) with
    // Q^k = [[p, q], [q, p+q]].
    function automatic uop_t uop_rom(input pc_t pc);
        uop_t u;
        unique case (pc)
            4'd0:    u = '{OP_ADD, SEL_BP, SEL_BQ, SEL_BR};
            4'd1:    u = '{OP_MUL, SEL_AP, SEL_BQ, SEL_T0};
            4'd2:    u = '{OP_MUL, SEL_AP, SEL_BP, SEL_AP};
            4'd3:    u = '{OP_MUL, SEL_AQ, SEL_BQ, SEL_T1};
            4'd4:    u = '{OP_ADD, SEL_AP, SEL_T1, SEL_AP};
            4'd5:    u = '{OP_MUL, SEL_AQ, SEL_BR, SEL_T1};
            4'd6:    u = '{OP_ADD, SEL_T0, SEL_T1, SEL_AQ};
            4'd7:    u = '{OP_ADD, SEL_BP, SEL_BR, SEL_T0};
            4'd8:    u = '{OP_MUL, SEL_BP, SEL_BP, SEL_T1};
            4'd9:    u = '{OP_MUL, SEL_BQ, SEL_BQ, SEL_T2};
            4'd10:   u = '{OP_MUL, SEL_BQ, SEL_T0, SEL_BQ};
            4'd11:   u = '{OP_ADD, SEL_T1, SEL_T2, SEL_BP};
            default: u = '{OP_ADD, SEL_T0, SEL_T0, SEL_T0};
        endcase
        return u;
    endfunction

endpackage

// File: rtl/core/fibmod_if.sv
// ============================================================================
// fibmod_if
// Valid/ready channels for exponent requests and results.
// ============================================================================
interface fibmod_exp_if;
    import fibmod_pkg::*;

    logic             valid;
    logic             ready;
    logic [EXP_W-1:0] exponent;

    modport source (output valid, output exponent, input ready);
    modport sink   (input valid, input exponent, output ready);
endinterface

interface fibmod_res_if;
    import fibmod_pkg::*;

    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] fib_mod;

    modport source (output valid, output fib_mod, input ready);
    modport sink   (input valid, input fib_mod, output ready);
endinterface

// File: rtl/core/fibmod_recip.sv
// ============================================================================
// fibmod_recip
// Restoring divider: mu = floor((2^32 - 1) / m), one quotient bit per cycle.
// ============================================================================
module fibmod_recip (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fibmod_pkg::MEFF_W-1:0] divisor,
    output logic                          busy,
    output logic [fibmod_pkg::MU_W-1:0]   mu
);
    import fibmod_pkg::*;

    localparam int CNT_W = $clog2(MU_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MEFF_W-1:0] rem_reg, rem_next;
    logic [MU_W-1:0]   quo_reg, quo_next;
    logic [MEFF_W:0]   trial;
    logic              fits;

    // dividend is all ones, so every shifted-in bit is 1
    assign trial = {rem_reg, 1'b1};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[MU_W-2:0], fits};
            rem_next = fits ? MEFF_W'(trial - {1'b0, divisor}) : trial[MEFF_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MU_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= MU_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign mu   = quo_reg;

endmodule

// File: rtl/core/fibmod_mmu.sv
// ============================================================================
// fibmod_mmu
// Shared modular unit: x*y mod m (Barrett, one 32x32 multiplier) or x+y mod m.
// ============================================================================
module fibmod_mmu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fibmod_pkg::mm_req_t           req,
    input  logic [fibmod_pkg::MOD_W-1:0]  x,
    input  logic [fibmod_pkg::MOD_W-1:0]  y,
    input  logic [fibmod_pkg::MEFF_W-1:0] m,
    input  logic [fibmod_pkg::MU_W-1:0]   mu,
    output fibmod_pkg::mm_stat_t          stat
);
    import fibmod_pkg::*;

    mm_state_t          state_reg, state_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [MU_W-1:0]    t_reg;
    logic [RED_W-1:0]   r_reg;
    logic [MU_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic               fits;

    // operand select for the single multiplier
    always_comb
    begin
        case (state_reg)
            MM_EST:
            begin
                mul_a = prod_reg[MU_W-1:0];
                mul_b = mu;
            end
            MM_BACK:
            begin
                mul_a = prod_reg[PROD_W-1:MU_W];
                mul_b = MU_W'(m);
            end
            default:
            begin
                mul_a = MU_W'(x);
                mul_b = MU_W'(y);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign fits  = r_reg >= RED_W'(m);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MM_IDLE:
            begin
                if (req.start)
                begin
                    state_next = (req.op == OP_ADD) ? MM_FIX : MM_EST;
                end
            end
            MM_EST:  state_next = MM_BACK;
            MM_BACK: state_next = MM_SUB;
            MM_SUB:  state_next = MM_FIX;
            MM_FIX:
            begin
                if (!fits)
                begin
                    state_next = MM_IDLE;
                end
            end
            default: state_next = MM_IDLE;
        endcase
    end

    always_comb
    begin
        stat.done = (state_reg == MM_FIX) && !fits;
        stat.r    = r_reg[MOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // t = x*y; q ~ t*mu >> 32; r = t - q*m lands below 3m
    always_ff @(posedge clk)
    begin
        case (state_reg)
            MM_IDLE:
            begin
                if (req.start)
                begin
                    prod_reg <= mul_p;
                    r_reg    <= RED_W'(x) + RED_W'(y);
                end
            end
            MM_EST:
            begin
                t_reg    <= prod_reg[MU_W-1:0];
                prod_reg <= mul_p;
            end
            MM_BACK:
            begin
                prod_reg <= mul_p;
            end
            MM_SUB:
            begin
                r_reg <= t_reg[RED_W-1:0] - prod_reg[RED_W-1:0];
            end
            MM_FIX:
            begin
                if (fits)
                begin
                    r_reg <= r_reg - RED_W'(m);
                end
            end
            default:
            begin
                r_reg <= r_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == MM_IDLE)
        else $error("modular unit started while busy");

    a_barrett_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == MM_SUB |=> r_reg < (RED_W'(m) + RED_W'(m) + RED_W'(m)))
        else $error("Barrett remainder not below 3m");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> state_reg == MM_IDLE)
        else $error("modular unit did not return to idle after finishing");
`endif

endmodule

// File: rtl/core/fibonacci_mod_matrix_power.sv
// ============================================================================
// fibonacci_mod_matrix_power
// F(n) mod m by binary exponentiation of [[0,1],[1,1]].
// ============================================================================
// Accepts an exponent n on the operand channel and returns F(n) modulo the
// modulus register (APB offset 0x0, reset 10000; 0 acts as 65536) on the
// result channel. Each power of [[0,1],[1,1]] is held as the pair
// (F(k-1), F(k)), and a 12-step sequencer drives one shared modular unit
// built around a single 32x32 multiplier with Barrett reduction. Exponent
// bits are walked LSB first and the run stops after the highest set bit.
// Set bits run the accumulate steps before the squaring steps, clear bits
// only the squaring steps; a modular product passes the estimate,
// back-multiply, subtract and fix-up states, a modular add only the fix-up
// state; n = 0 goes straight to the result. One request is in flight at a
// time; a finished result waits in its own output register, so the next
// request is taken meanwhile. A modulus write recomputes the Barrett
// reciprocal, during which no request is accepted.
// ============================================================================
module fibonacci_mod_matrix_power #(
    parameter int EXP_BITS = 31
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fibmod_exp_if.sink                    operand,
    fibmod_res_if.source                  result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fibmod_pkg::ADDR_W-1:0] paddr,
    input  logic [fibmod_pkg::DATA_W-1:0] pwdata,
    output logic [fibmod_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);
    import fibmod_pkg::*;

    // exponent bits actually used
    localparam int NB = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;

    state_t             state_reg, state_next;
    pc_t                pc_reg;
    logic [NB-1:0]      exp_reg;
    logic [MOD_W-1:0]   modulus_reg;
    logic [MEFF_W-1:0]  m_eff;
    logic [MOD_W-1:0]   ap_reg, aq_reg, bp_reg, bq_reg, br_reg;
    logic [MOD_W-1:0]   t0_reg, t1_reg, t2_reg;
    logic               out_valid_reg;
    logic [MOD_W-1:0]   out_data_reg;

    logic               cfg_wr, cfg_hit;
    logic               recip_busy;
    logic [MU_W-1:0]    mu;
    logic               accept;
    logic               exp_empty, last_bit, load_out;
    uop_t               uop;
    logic [MOD_W-1:0]   opa, opb;
    mm_req_t            mm_req;
    mm_stat_t           mm_stat;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_hit = paddr[ADDR_W-1:2] == REG_MODULUS;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = cfg_hit ? DATA_W'(modulus_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
        end
        else if (cfg_wr && cfg_hit)
        begin
            modulus_reg <= pwdata[MOD_W-1:0];
        end
    end

    assign m_eff = (modulus_reg == '0) ? {1'b1, {MOD_W{1'b0}}} : {1'b0, modulus_reg};

    fibmod_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_wr && cfg_hit),
        .divisor (m_eff),
        .busy    (recip_busy),
        .mu      (mu)
    );

    // ---------------- sequencer ----------------
    assign operand.ready = (state_reg == ST_IDLE) && !recip_busy;
    assign accept        = operand.valid && operand.ready;
    assign exp_empty     = exp_reg == '0;
    assign last_bit      = (exp_reg >> 1) == '0;
    assign uop           = uop_rom(pc_reg);

    always_comb
    begin
        case (uop.a)
            SEL_AP: opa = ap_reg;
            SEL_AQ: opa = aq_reg;
            SEL_BP: opa = bp_reg;
            SEL_BQ: opa = bq_reg;
            SEL_BR: opa = br_reg;
            SEL_T0: opa = t0_reg;
            SEL_T1: opa = t1_reg;
            SEL_T2: opa = t2_reg;
        endcase
        case (uop.b)
            SEL_AP: opb = ap_reg;
            SEL_AQ: opb = aq_reg;
            SEL_BP: opb = bp_reg;
            SEL_BQ: opb = bq_reg;
            SEL_BR: opb = br_reg;
            SEL_T0: opb = t0_reg;
            SEL_T1: opb = t1_reg;
            SEL_T2: opb = t2_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = (pc_reg == PC_BR && exp_empty) ? ST_DONE : ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mm_stat.done)
                begin
                    // no higher set bit: skip the final squaring
                    state_next = (pc_reg == PC_ACC_END && last_bit) ? ST_DONE : ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        mm_req.start = (state_reg == ST_ISSUE) && !(pc_reg == PC_BR && exp_empty);
        mm_req.op    = uop.op;
        load_out     = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= PC_BR;
            exp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                pc_reg  <= PC_BR;
                exp_reg <= operand.exponent[NB-1:0];
            end
            else if (state_reg == ST_WAIT && mm_stat.done)
            begin
                case (pc_reg)
                    PC_BR:
                    begin
                        pc_reg <= exp_reg[0] ? PC_ACC : PC_SQR;
                    end
                    PC_SQR_END:
                    begin
                        pc_reg  <= PC_BR;
                        exp_reg <= exp_reg >> 1;
                    end
                    default:
                    begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // element registers: acc = identity, base = Q
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ap_reg <= MOD_W'(1);
            aq_reg <= '0;
            bp_reg <= '0;
            bq_reg <= MOD_W'(1);
        end
        else if (state_reg == ST_WAIT && mm_stat.done)
        begin
            case (uop.dst)
                SEL_AP: ap_reg <= mm_stat.r;
                SEL_AQ: aq_reg <= mm_stat.r;
                SEL_BP: bp_reg <= mm_stat.r;
                SEL_BQ: bq_reg <= mm_stat.r;
                SEL_BR: br_reg <= mm_stat.r;
                SEL_T0: t0_reg <= mm_stat.r;
                SEL_T1: t1_reg <= mm_stat.r;
                SEL_T2: t2_reg <= mm_stat.r;
            endcase
        end
        if (load_out)
        begin
            out_data_reg <= aq_reg;
        end
    end

    fibmod_mmu u_mmu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .x     (opa),
        .y     (opb),
        .m     (m_eff),
        .mu    (mu),
        .stat  (mm_stat)
    );

    assign result.valid   = out_valid_reg;
    assign result.fib_mod = out_data_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> {1'b0, result.fib_mod} < m_eff)
        else $error("result not reduced below modulus");

    a_recip_block: assert property (@(posedge clk) disable iff (!rst_n)
        recip_busy |-> !operand.ready)
        else $error("request taken while reciprocal is being computed");

    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mm_stat.done |-> state_reg == ST_WAIT)
        else $error("modular unit finished with no step pending");
`endif

endmodule
